/* sv/trellis_map_decoder_core_macros.svh */
// Assertion helpers for the MAP decoder core
`ifndef TRELLIS_MAP_DECODER_CORE_MACROS_SVH
`define TRELLIS_MAP_DECODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define TMD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked out of reset
`define TMD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TMD_ASSERT_IMP(name, ante, cons, msg)
`define TMD_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

/* sv/tmd_pkg.sv */
package tmd_pkg;

  // metric and accumulator widths
  localparam int MET_W      = 17;
  localparam int ACC_W      = 40;
  localparam int LP_W       = 56;
  localparam int NST        = 16;
  localparam int NST_W      = 4;
  localparam int NIN        = 4;
  localparam int NIN_W      = 2;
  localparam int EDGE_AW    = 6;
  localparam int NEDGE      = 64;
  localparam int PBUF       = 256;
  localparam int PBUF_AW    = 8;
  localparam int MAX_STAGES = 64;
  localparam int STG_W      = 7;
  localparam int MET_DEPTH  = (MAX_STAGES + 1) * NST;
  localparam int MET_AW     = $clog2(MET_DEPTH);
  localparam int GAM_DEPTH  = MAX_STAGES * NEDGE;
  localparam int GAM_AW     = $clog2(GAM_DEPTH);
  localparam int DIV_STEPS  = MET_W;

  typedef logic [MET_W-1:0] metric_t;
  typedef logic [ACC_W-1:0] acc_t;
  typedef logic [LP_W-1:0]  lp_t;

  localparam metric_t Q_ONE = metric_t'(65536);

  // configuration register indexes
  localparam logic [1:0] CFG_BITS_IN  = 2'd0;
  localparam logic [1:0] CFG_BITS_OUT = 2'd1;
  localparam logic [1:0] CFG_MEM_ORD  = 2'd2;
  localparam logic [1:0] CFG_STAGES   = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [3:0]       edge_from_state;
    logic [1:0]       edge_in_label;
    logic [3:0]       edge_to_state;
    logic [3:0]       edge_out_label;
    logic [MET_W-1:0] bit_zero_prob;
  } in_item_t;

  typedef struct packed {
    logic [1:0] decided_label;
    logic [5:0] stage_index;
    logic       last_stage;
  } out_item_t;

  typedef struct packed {
    logic [3:0] to_st;
    logic [3:0] olab;
  } edge_t;

  typedef struct packed {
    logic start;
    acc_t num;
    acc_t den;
  } div_req_t;

  typedef struct packed {
    logic    done;
    metric_t quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_F_ROWRD, S_F_ROW, S_F_J, S_F_EDGE, S_F_MUL, S_F_MULW, S_F_PRD,
    S_F_GAM, S_F_ACC, S_F_DIV, S_F_DIVW, S_F_END,
    S_B_ROWRD, S_B_ROW, S_B_J, S_B_EDGE, S_B_BETA, S_B_T, S_B_LO, S_B_HI,
    S_B_DIV, S_B_DIVW, S_B_PICK, S_B_END,
    S_O_RD, S_O_OUT
  } state_t;

endpackage

/* sv/trellis_map_decoder_core.sv */
// Channel   Ports                          Beat taken when
// input     start, busy, in_data           start && !busy
// result    out_strobe, out_data           out_strobe (one cycle, no back-pressure)
// config    cfg_we, cfg_index, cfg_data    cfg_we
//
// An edge load or a non-final probability is stored while busy stays low.
// The final probability of a frame starts a decode through one shared 17x17
// multiplier and a bit-serial divider: a forward pass, a backward pass, then
// one result per stage with out_strobe low between beats; busy stays high
// until the last beat.
// Reset is synchronous; tables and buffers are not cleared.
module trellis_map_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tmd_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output tmd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);
  import tmd_pkg::*;

  `include "trellis_map_decoder_core_macros.svh"

  // configuration
  logic [1:0] cfg_k_r;
  logic [2:0] cfg_n_r;
  logic [2:0] cfg_m_r;
  logic [6:0] cfg_s_r;

  logic             k2;
  logic [2:0]       nb_eff;
  logic [2:0]       m_eff;
  logic [STG_W-1:0] s_eff;
  logic [NST_W-1:0] ns_mask;
  logic [NIN_W-1:0] nin_mask;
  logic [8:0]       total;

  // sequencer and datapath
  state_t state_r, state_nxt;
  logic [STG_W-1:0]   stg_r;
  logic [STG_W-1:0]   stg_p1;
  logic [NST_W-1:0]   j_r;
  logic [NIN_W-1:0]   c_r;
  logic [1:0]         b_r;
  logic [PBUF_AW-1:0] pbase_r;
  logic [NST-1:0]     row_r;
  logic [NST-1:0]     nrow_r;
  logic [NST_W-1:0]   nxt_r;
  logic [3:0]         lab_r;
  metric_t            prod_r;
  metric_t            alpha_r;
  metric_t            gam_r;
  logic [2*MET_W-1:0] mul_r;
  logic [2*MET_W-1:0] t_r;
  acc_t               sum_r;
  acc_t               acc_r [NST];
  lp_t                lp_r [NIN];
  lp_t                best_v_r;
  logic [NIN_W-1:0]   best_r;
  logic [8:0]         prob_cnt_r;

  logic [EDGE_AW-1:0] e_cur;
  logic [NST_W-1:0]   acc_idx;
  acc_t               acc_rd;
  lp_t                lp_rd;
  logic               j_last;
  logic               c_last;
  logic               row_hit;
  logic               nrow_hit;
  logic               sum_nz;
  logic               in_go;
  logic [8:0]         cnt_inc;
  logic               frame_done;
  metric_t            p_sat;
  metric_t            f_val;
  metric_t            gamma;
  metric_t            beta_v;
  metric_t            mul_a;
  metric_t            mul_b;

  // memories
  edge_t          edge_mem  [NEDGE];
  metric_t        prob_mem  [PBUF];
  metric_t        gam_mem   [GAM_DEPTH];
  metric_t        alpha_mem [MET_DEPTH];
  metric_t        beta_mem  [MET_DEPTH];
  logic [NST-1:0] reach_mem [MAX_STAGES+1];
  logic [1:0]     dec_mem   [MAX_STAGES];

  edge_t          edge_q;
  metric_t        prob_q;
  metric_t        gam_q;
  metric_t        alpha_q;
  metric_t        beta_q;
  logic [NST-1:0] reach_q;
  logic [1:0]     dec_q;

  logic               edge_ok;
  logic [EDGE_AW-1:0] edge_wa;
  logic [MET_AW-1:0]  beta_ra;
  logic               alpha_we;
  logic               beta_we;
  metric_t            met_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tmd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // register clamps
  assign k2       = cfg_k_r[1];
  assign nin_mask = k2 ? 2'd3 : 2'd1;
  assign nb_eff   = (cfg_n_r == 3'd0) ? 3'd1 : ((cfg_n_r > 3'd4) ? 3'd4 : cfg_n_r);
  assign m_eff    = (cfg_m_r == 3'd0) ? 3'd1 : ((cfg_m_r > 3'd4) ? 3'd4 : cfg_m_r);
  assign s_eff    = (cfg_s_r == 7'd0) ? 7'd1 :
                    ((cfg_s_r > 7'(MAX_STAGES)) ? 7'(MAX_STAGES) : cfg_s_r);
  assign ns_mask  = 4'((5'd1 << m_eff) - 5'd1);
  assign total    = 9'(s_eff) * 9'(nb_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_k_r <= 2'd1;
      cfg_n_r <= 3'd2;
      cfg_m_r <= 3'd2;
      cfg_s_r <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BITS_IN:  cfg_k_r <= cfg_data[1:0];
        CFG_BITS_OUT: cfg_n_r <= cfg_data[2:0];
        CFG_MEM_ORD:  cfg_m_r <= cfg_data[2:0];
        CFG_STAGES:   cfg_s_r <= cfg_data;
        default:      cfg_k_r <= cfg_k_r;
      endcase
    end
  end

  // shared helpers
  assign stg_p1   = stg_r + 7'd1;
  assign e_cur    = k2 ? {j_r, c_r} : {1'b0, j_r, c_r[0]};
  assign j_last   = (j_r == ns_mask);
  assign c_last   = (c_r == nin_mask);
  assign row_hit  = row_r[j_r];
  assign nrow_hit = nrow_r[j_r];
  assign sum_nz   = (sum_r != '0);
  assign acc_idx  = (state_r == S_F_ACC) ? nxt_r : j_r;
  assign acc_rd   = acc_r[acc_idx];
  assign lp_rd    = lp_r[c_r];
  assign in_go    = start && !busy;
  assign cnt_inc  = prob_cnt_r + 9'd1;
  assign frame_done = in_data.req_type && (cnt_inc >= total);

  assign p_sat  = (prob_q > Q_ONE) ? Q_ONE : prob_q;
  assign f_val  = lab_r[0] ? metric_t'(Q_ONE - p_sat) : p_sat;
  assign gamma  = k2 ? (prod_r >> 2) : (prod_r >> 1);
  assign beta_v = (stg_p1 == s_eff) ? Q_ONE : beta_q;

  // probability counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prob_cnt_r <= '0;
    end else if (in_go && in_data.req_type) begin
      prob_cnt_r <= frame_done ? 9'd0 : cnt_inc;
    end
  end

  // edge table and probability buffer
  assign edge_ok = (in_data.edge_from_state <= ns_mask) && (in_data.edge_in_label <= nin_mask);
  assign edge_wa = k2 ? {in_data.edge_from_state, in_data.edge_in_label}
                      : {1'b0, in_data.edge_from_state, in_data.edge_in_label[0]};

  always_ff @(posedge clk) begin
    if (in_go && !in_data.req_type && edge_ok) begin
      edge_mem[edge_wa] <= '{to_st: in_data.edge_to_state, olab: in_data.edge_out_label};
    end
    edge_q <= edge_mem[e_cur];
  end

  always_ff @(posedge clk) begin
    if (in_go && in_data.req_type && !prob_cnt_r[8]) begin
      prob_mem[prob_cnt_r[PBUF_AW-1:0]] <= in_data.bit_zero_prob;
    end
    prob_q <= prob_mem[PBUF_AW'(pbase_r + PBUF_AW'(b_r))];
  end

  // branch metrics, indexed by stage and edge
  always_ff @(posedge clk) begin
    if (state_r == S_F_GAM) begin
      gam_mem[{stg_r[5:0], e_cur}] <= gamma;
    end
    gam_q <= gam_mem[{stg_r[5:0], e_cur}];
  end

  // forward and backward metrics
  assign alpha_we = ((state_r == S_F_DIV) && nrow_hit && !sum_nz) ||
                    ((state_r == S_F_DIVW) && div_rsp.done);
  assign beta_we  = ((state_r == S_B_DIV) && row_hit && !sum_nz) ||
                    ((state_r == S_B_DIVW) && div_rsp.done);
  assign met_wd   = ((state_r == S_F_DIVW) || (state_r == S_B_DIVW)) ? div_rsp.quo : '0;
  assign beta_ra  = {stg_p1, edge_q.to_st & ns_mask};

  always_ff @(posedge clk) begin
    if (alpha_we) begin
      alpha_mem[{stg_p1, j_r}] <= met_wd;
    end
    alpha_q <= alpha_mem[{stg_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (beta_we) begin
      beta_mem[{stg_r, j_r}] <= met_wd;
    end
    beta_q <= beta_mem[beta_ra];
  end

  // reachable state rows and decisions
  always_ff @(posedge clk) begin
    if (state_r == S_F_END) begin
      reach_mem[stg_p1] <= nrow_r;
    end
    reach_q <= reach_mem[stg_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_B_END) begin
      dec_mem[stg_r[5:0]] <= best_r;
    end
    dec_q <= dec_mem[stg_r[5:0]];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_F_MUL:  begin mul_a = prod_r;  mul_b = f_val;                 end
      S_F_GAM:  begin mul_a = gamma;   mul_b = alpha_r;               end
      S_B_BETA: begin mul_a = gam_r;   mul_b = beta_v;                end
      S_B_T:    begin mul_a = alpha_r; mul_b = mul_r[MET_W-1:0];      end
      S_B_LO:   begin mul_a = alpha_r; mul_b = t_r[2*MET_W-1:MET_W];  end
      default:  begin mul_a = '0;      mul_b = '0;                    end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_go && frame_done) state_nxt = S_F_ROWRD;
      S_F_ROWRD: state_nxt = S_F_ROW;
      S_F_ROW:   state_nxt = S_F_J;
      S_F_J: begin
        if (row_hit) state_nxt = S_F_EDGE;
        else if (j_last) state_nxt = S_F_DIV;
      end
      S_F_EDGE:  state_nxt = S_F_MUL;
      S_F_MUL:   state_nxt = S_F_MULW;
      S_F_MULW:  state_nxt = (b_r == 2'd0) ? S_F_GAM : S_F_PRD;
      S_F_PRD:   state_nxt = S_F_MUL;
      S_F_GAM:   state_nxt = S_F_ACC;
      S_F_ACC:   state_nxt = (c_last && j_last) ? S_F_DIV : S_F_J;
      S_F_DIV: begin
        if (nrow_hit && sum_nz) state_nxt = S_F_DIVW;
        else if (j_last) state_nxt = S_F_END;
      end
      S_F_DIVW:  if (div_rsp.done) state_nxt = j_last ? S_F_END : S_F_DIV;
      S_F_END:   state_nxt = (stg_p1 == s_eff) ? S_B_ROWRD : S_F_ROWRD;
      S_B_ROWRD: state_nxt = S_B_ROW;
      S_B_ROW:   state_nxt = S_B_J;
      S_B_J: begin
        if (row_hit) state_nxt = S_B_EDGE;
        else if (j_last) state_nxt = S_B_DIV;
      end
      S_B_EDGE:  state_nxt = S_B_BETA;
      S_B_BETA:  state_nxt = S_B_T;
      S_B_T:     state_nxt = S_B_LO;
      S_B_LO:    state_nxt = S_B_HI;
      S_B_HI:    state_nxt = (c_last && j_last) ? S_B_DIV : S_B_J;
      S_B_DIV: begin
        if (row_hit && sum_nz) state_nxt = S_B_DIVW;
        else if (j_last) state_nxt = S_B_PICK;
      end
      S_B_DIVW:  if (div_rsp.done) state_nxt = j_last ? S_B_PICK : S_B_DIV;
      S_B_PICK:  if (c_last) state_nxt = S_B_END;
      S_B_END:   state_nxt = (stg_r == '0) ? S_O_RD : S_B_ROWRD;
      S_O_RD:    state_nxt = S_O_OUT;
      S_O_OUT:   state_nxt = (stg_p1 == s_eff) ? S_IDLE : S_O_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs and divider request
  always_comb begin
    busy                   = (state_r != S_IDLE);
    out_strobe             = (state_r == S_O_OUT);
    out_data.decided_label = dec_q;
    out_data.stage_index   = stg_r[5:0];
    out_data.last_stage    = (stg_p1 == s_eff);
    div_req.start          = ((state_r == S_F_DIV) && nrow_hit && sum_nz) ||
                             ((state_r == S_B_DIV) && row_hit && sum_nz);
    div_req.num            = acc_rd;
    div_req.den            = sum_r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        stg_r   <= '0;
        pbase_r <= '0;
      end
      S_F_ROW, S_B_ROW: begin
        row_r    <= (stg_r == '0) ? NST'(1) : reach_q;
        nrow_r   <= '0;
        j_r      <= '0;
        c_r      <= '0;
        sum_r    <= '0;
        best_v_r <= '0;
        best_r   <= '0;
        for (int i = 0; i < NST; i++) acc_r[i] <= '0;
        for (int i = 0; i < NIN; i++) lp_r[i] <= '0;
      end
      S_F_J: begin
        if (row_hit) b_r <= 2'(nb_eff - 3'd1);
        else j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_F_EDGE: begin
        nxt_r   <= edge_q.to_st & ns_mask;
        lab_r   <= edge_q.olab;
        alpha_r <= (stg_r == '0) ? Q_ONE : alpha_q;
        prod_r  <= Q_ONE;
        nrow_r[edge_q.to_st & ns_mask] <= 1'b1;
      end
      S_F_MULW: begin
        prod_r <= mul_r[32:16];
        lab_r  <= lab_r >> 1;
        if (b_r != 2'd0) b_r <= b_r - 2'd1;
      end
      S_F_ACC: begin
        acc_r[nxt_r] <= acc_rd + ACC_W'(mul_r);
        sum_r        <= sum_r + ACC_W'(mul_r);
        c_r          <= c_last ? '0 : c_r + 2'd1;
        if (c_last) j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_F_DIV, S_B_DIV: begin
        if (!div_req.start) j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_F_DIVW, S_B_DIVW: begin
        if (div_rsp.done) j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_F_END: begin
        pbase_r <= pbase_r + PBUF_AW'(nb_eff);
        if (stg_p1 != s_eff) stg_r <= stg_p1;
      end
      S_B_J: begin
        if (!row_hit) j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_B_EDGE: begin
        gam_r   <= gam_q;
        alpha_r <= (stg_r == '0) ? Q_ONE : alpha_q;
      end
      S_B_T: begin
        t_r        <= mul_r;
        acc_r[j_r] <= acc_rd + ACC_W'(mul_r);
        sum_r      <= sum_r + ACC_W'(mul_r);
      end
      S_B_LO: begin
        lp_r[c_r] <= lp_rd + LP_W'(mul_r);
      end
      S_B_HI: begin
        lp_r[c_r] <= lp_rd + (LP_W'(mul_r) << MET_W);
        c_r       <= c_last ? '0 : c_r + 2'd1;
        if (c_last) j_r <= j_last ? '0 : j_r + 4'd1;
      end
      S_B_PICK: begin
        // strict compare keeps the lowest label on a tie
        if (lp_rd > best_v_r) begin
          best_v_r <= lp_rd;
          best_r   <= c_r;
        end
        c_r <= c_last ? '0 : c_r + 2'd1;
      end
      S_B_END: begin
        if (stg_r != '0) stg_r <= stg_r - 7'd1;
      end
      S_O_OUT: begin
        stg_r <= stg_p1;
      end
      default: begin
        stg_r <= stg_r;
      end
    endcase
  end

  // checks
  `TMD_ASSERT_IMP(a_strobe_busy, out_strobe, busy, "result beat outside a decode")
  `TMD_ASSERT_NXT(a_last_idle, out_strobe && out_data.last_stage, !busy, "busy after last beat")
  `TMD_ASSERT_NXT(a_beat_gap, out_strobe && !out_data.last_stage, busy && !out_strobe, "beat spacing")
  `TMD_ASSERT_IMP(a_div_den, div_req.start, div_req.den != '0, "divide by zero sum")

endmodule

/* sv/tmd_div.sv */
module tmd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  tmd_pkg::div_req_t req,
  output tmd_pkg::div_rsp_t rsp
);
  import tmd_pkg::*;

  logic             run_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  acc_t             rem_r;
  acc_t             den_r;
  logic [MET_W-1:0] low_r;
  metric_t          quo_r;
  logic [ACC_W:0]   rem_sh;
  logic             ge;

  // one quotient bit per cycle: floor(num * 2^16 / den), num <= den
  assign rem_sh = {rem_r, low_r[MET_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd1);
      if (req.start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == 5'd1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num >> 1;
      low_r <= {req.num[0], {(MET_W-1){1'b0}}};
      quo_r <= '0;
      cnt_r <= 5'(DIV_STEPS);
      den_r <= req.den;
    end else if (run_r) begin
      rem_r <= ge ? ACC_W'(rem_sh - {1'b0, den_r}) : rem_sh[ACC_W-1:0];
      quo_r <= {quo_r[MET_W-2:0], ge};
      low_r <= low_r << 1;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* bench/trellis_map_decoder_core_test.sv */
`timescale 1ns / 100ps

module trellis_map_decoder_core_test;
  import tmd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic busy_q;
  in_item_t in_data = '0;
  logic out_strobe;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  trellis_map_decoder_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // decoder shadow state
  int unsigned k_reg, n_reg, m_reg, s_reg;
  logic [3:0] next_tbl [NEDGE];
  logic [3:0] olab_tbl [NEDGE];
  int unsigned prob_mem [PBUF];
  int unsigned prob_cnt;

  in_item_t pending_beats[$];
  out_item_t decisions_due[$];
  int unsigned error_count = 0;
  int unsigned decision_count = 0;
  int unsigned frame_count = 0;
  longint unsigned cycle_count = 0;
  bit no_gaps = 1'b0;
  bit hold_tx = 1'b0;

  function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // full BCJR pass over the stored frame, pushes one decision per stage
  task automatic decode_frame_expect();
    int unsigned k, nb, ns, nst_cnt, nin, e, lab, p, f, best, tgt;
    bit reach [MAX_STAGES+1][NST];
    longint unsigned gam [MAX_STAGES][NEDGE];
    longint unsigned alp [MAX_STAGES+1][NST];
    longint unsigned bet [MAX_STAGES+1][NST];
    longint unsigned acc [NST];
    longint unsigned lp [NIN];
    longint unsigned sum, prod;
    out_item_t d;
    k = sat(k_reg, 1, 2);
    nb = sat(n_reg, 1, 4);
    ns = 1 << sat(m_reg, 1, 4);
    nst_cnt = sat(s_reg, 1, 64);
    nin = 1 << k;
    for (int i = 0; i <= MAX_STAGES; i++)
      for (int j = 0; j < NST; j++) begin
        reach[i][j] = 0; alp[i][j] = 0; bet[i][j] = 0;
      end
    for (int i = 0; i < MAX_STAGES; i++)
      for (int j = 0; j < NEDGE; j++) gam[i][j] = 0;
    reach[0][0] = 1;
    alp[0][0] = 65536;
    for (int j = 0; j < ns; j++) bet[nst_cnt][j] = 65536;
    // branch metrics and reachability
    for (int i = 0; i < nst_cnt; i++)
      for (int j = 0; j < ns; j++) begin
        if (!reach[i][j]) continue;
        for (int c = 0; c < nin; c++) begin
          e = (j << k) | c;
          lab = olab_tbl[e];
          prod = 65536;
          reach[i+1][next_tbl[e] & (ns-1)] = 1;
          for (int b = nb - 1; b >= 0; b--) begin
            p = prob_mem[(i*nb + b) % PBUF];
            if (p > 65536) p = 65536;
            f = (lab & 1) ? 65536 - p : p;
            prod = (prod * f) >> 16;
            lab = lab >> 1;
          end
          gam[i][e] = prod >> k;
        end
      end
    // forward recursion
    for (int i = 0; i < nst_cnt; i++) begin
      for (int j = 0; j < NST; j++) acc[j] = 0;
      for (int j = 0; j < ns; j++) begin
        if (!reach[i][j]) continue;
        for (int c = 0; c < nin; c++) begin
          e = (j << k) | c;
          tgt = next_tbl[e] & (ns-1);
          acc[tgt] += gam[i][e] * alp[i][j];
        end
      end
      sum = 0;
      for (int j = 0; j < ns; j++) if (reach[i+1][j]) sum += acc[j];
      if (sum != 0)
        for (int j = 0; j < ns; j++)
          if (reach[i+1][j]) alp[i+1][j] = (acc[j] * 65536) / sum;
    end
    // backward recursion
    for (int i = nst_cnt - 1; i >= 0; i--) begin
      sum = 0;
      for (int j = 0; j < ns; j++) begin
        acc[j] = 0;
        if (!reach[i][j]) continue;
        for (int c = 0; c < nin; c++) begin
          e = (j << k) | c;
          acc[j] += gam[i][e] * bet[i+1][next_tbl[e] & (ns-1)];
        end
        sum += acc[j];
      end
      if (sum != 0)
        for (int j = 0; j < ns; j++)
          if (reach[i][j]) bet[i][j] = (acc[j] * 65536) / sum;
    end
    // per-stage decision, lowest label wins ties
    for (int i = 0; i < nst_cnt; i++) begin
      for (int c = 0; c < NIN; c++) lp[c] = 0;
      for (int j = 0; j < ns; j++) begin
        if (!reach[i][j]) continue;
        for (int c = 0; c < nin; c++) begin
          e = (j << k) | c;
          lp[c] += alp[i][j] * gam[i][e] * bet[i+1][next_tbl[e] & (ns-1)];
        end
      end
      best = 0;
      for (int c = 1; c < nin; c++) if (lp[c] > lp[best]) best = c;
      d.decided_label = best[1:0];
      d.stage_index = i[5:0];
      d.last_stage = (i == nst_cnt - 1);
      decisions_due.push_back(d);
    end
    frame_count++;
  endtask

  // one accepted input beat
  task automatic apply_beat(in_item_t it);
    int unsigned k, ns, total, e;
    k = sat(k_reg, 1, 2);
    ns = 1 << sat(m_reg, 1, 4);
    total = sat(s_reg, 1, 64) * sat(n_reg, 1, 4);
    if (!it.req_type) begin
      if (it.edge_from_state < ns && it.edge_in_label < (1 << k)) begin
        e = ((it.edge_from_state << k) | it.edge_in_label) % NEDGE;
        next_tbl[e] = it.edge_to_state;
        olab_tbl[e] = it.edge_out_label;
      end
      return;
    end
    if (prob_cnt < PBUF) prob_mem[prob_cnt] = 32'(it.bit_zero_prob);
    prob_cnt = (prob_cnt + 1) & 511;
    if (prob_cnt >= total) begin
      prob_cnt = 0;
      decode_frame_expect();
    end
  endtask

  // busy as seen at the last rising edge
  always @(posedge clk) busy_q <= busy;

  // driver: falling-edge updates; a beat still waiting stays on the ports
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy_q)) begin
      if (hold_tx || pending_beats.size() == 0) begin
        start <= 1'b0;
      end else if (!no_gaps && $urandom_range(99) < 29) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_data <= pending_beats.pop_front();
      end
    end
  end

  // input acceptance and output check at the rising edge
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && start && !busy) apply_beat(in_data);
    if (rst_n && out_strobe) begin
      if (decisions_due.size() == 0) begin
        $display("%0t: unexpected decision %p", $time, out_data);
        error_count++;
      end else begin
        automatic out_item_t exp_d = decisions_due.pop_front();
        decision_count++;
        if (out_data.decided_label !== exp_d.decided_label)
          $display("%0t: label mismatch expected %0d actual %0d", $time,
                   exp_d.decided_label, out_data.decided_label);
        if (out_data.stage_index !== exp_d.stage_index)
          $display("%0t: stage mismatch expected %0d actual %0d", $time,
                   exp_d.stage_index, out_data.stage_index);
        if (out_data.last_stage !== exp_d.last_stage)
          $display("%0t: last mismatch expected %0d actual %0d", $time,
                   exp_d.last_stage, out_data.last_stage);
        if (out_data !== exp_d) error_count++;
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t edge_beat(int unsigned fr, int unsigned lab, int unsigned to,
                                         int unsigned ol);
    in_item_t it;
    it = '0;
    it.bit_zero_prob = 17'($urandom_range(131071));
    it.req_type = 1'b0;
    it.edge_from_state = 4'(fr);
    it.edge_in_label = 2'(lab);
    it.edge_to_state = 4'(to);
    it.edge_out_label = 4'(ol);
    return it;
  endfunction

  function automatic in_item_t prob_beat(int unsigned p);
    in_item_t it;
    it = in_item_t'($urandom);
    it.req_type = 1'b1;
    it.bit_zero_prob = 17'(p);
    return it;
  endfunction

  function automatic int unsigned rand_prob();
    case ($urandom_range(9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(131071, 65537);
      3: return $urandom_range(65536, 60000);
      4: return $urandom_range(5000);
      default: return $urandom_range(65536);
    endcase
  endfunction

  // wait until no beat is pending, the block is idle and every decision is checked
  task automatic wait_drained();
    while (pending_beats.size() != 0 || start || busy || decisions_due.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[6:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BITS_IN:  k_reg = val & 3;
      CFG_BITS_OUT: n_reg = val & 7;
      CFG_MEM_ORD:  m_reg = val & 7;
      default:      s_reg = val & 127;
    endcase
  endtask

  // load every edge of the current trellis, random content
  task automatic load_trellis();
    int unsigned k, ns;
    k = sat(k_reg, 1, 2);
    ns = 1 << sat(m_reg, 1, 4);
    for (int j = 0; j < ns; j++)
      for (int c = 0; c < (1 << k); c++)
        pending_beats.push_back(edge_beat(j, c, $urandom_range(15), $urandom_range(15)));
  endtask

  // one frame of probabilities, with an occasional ignored edge mixed in
  task automatic send_frame(int unsigned nprob);
    for (int i = 0; i < nprob; i++) begin
      if ($urandom_range(9) == 0)
        pending_beats.push_back(edge_beat(15, 3, $urandom_range(15), $urandom_range(15)));
      pending_beats.push_back(prob_beat(rand_prob()));
    end
  endtask

  task automatic run_phase(int unsigned k, int unsigned n, int unsigned m, int unsigned s,
                           int unsigned frames);
    wait_drained();
    write_reg(CFG_BITS_IN, k);
    write_reg(CFG_BITS_OUT, n);
    write_reg(CFG_MEM_ORD, m);
    write_reg(CFG_STAGES, s);
    load_trellis();
    for (int f = 0; f < frames; f++)
      send_frame(sat(s_reg, 1, 64) * sat(n_reg, 1, 4));
  endtask

  initial begin
    k_reg = 1; n_reg = 2; m_reg = 2; s_reg = 64;
    prob_cnt = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: tiny frame, ties, clamps, duplicate and out-of-range edges
    write_reg(CFG_BITS_IN, 1);
    write_reg(CFG_BITS_OUT, 1);
    write_reg(CFG_MEM_ORD, 1);
    write_reg(CFG_STAGES, 2);
    pending_beats.push_back(edge_beat(0, 0, 0, 0));
    pending_beats.push_back(edge_beat(0, 1, 1, 15));
    pending_beats.push_back(edge_beat(1, 0, 0, 0));
    pending_beats.push_back(edge_beat(1, 1, 3, 1));
    pending_beats.push_back(edge_beat(1, 1, 1, 1));
    pending_beats.push_back(edge_beat(2, 0, 0, 0));
    pending_beats.push_back(edge_beat(0, 2, 0, 0));
    pending_beats.push_back(prob_beat(0));
    pending_beats.push_back(prob_beat(131071));
    pending_beats.push_back(prob_beat(32768));
    pending_beats.push_back(prob_beat(32768));
    pending_beats.push_back(prob_beat(65536));
    pending_beats.push_back(prob_beat(65537));
    // register values out of the used range, saturated by the block
    run_phase(0, 0, 0, 0, 2);
    run_phase(0, 7, 7, 1, 1);
    run_phase(3, 0, 1, 2, 1);

    // random widths, two frames; sender held after the first frame until it drains
    run_phase($urandom_range(2, 1), $urandom_range(4, 1), 2, 4, 2);
    while (decisions_due.size() == 0) @(posedge clk);
    hold_tx = 1'b1;
    while (start || busy || decisions_due.size() != 0) @(posedge clk);
    hold_tx = 1'b0;

    // long stretch with no gaps
    wait_drained();
    no_gaps = 1'b1;
    run_phase(1, 2, 2, 16, 1);
    wait_drained();
    no_gaps = 1'b0;

    // registers shrink in the middle of a frame
    write_reg(CFG_STAGES, 4);
    write_reg(CFG_BITS_OUT, 2);
    pending_beats.push_back(prob_beat(rand_prob()));
    pending_beats.push_back(prob_beat(rand_prob()));
    pending_beats.push_back(prob_beat(rand_prob()));
    wait_drained();
    write_reg(CFG_STAGES, 1);
    pending_beats.push_back(prob_beat(rand_prob()));
    run_phase(2, 1, 1, 4, 1);
    wait_drained();

    $display("Covered %0d frames, %0d stage decisions checked.", frame_count, decision_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
